>>> src/fpr_pkg.sv
// Shared types, constants and CRC function for the framed packet receiver.
package fpr_pkg;

  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'h55;
  localparam logic [7:0] CRC_INIT  = 8'hFF;
  localparam logic [7:0] CRC_POLY  = 8'h31;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_SEQ,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CRC,
    PH_TAIL
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_TYPE,
    ROLE_SEQ,
    ROLE_LEN_LO,
    ROLE_LEN_HI,
    ROLE_PAYLOAD,
    ROLE_CRC,
    ROLE_TAIL
  } role_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_ACCEPTED  = 3'd1,
    KIND_CRC_ERR   = 3'd2,
    KIND_BAD_TAIL  = 3'd3,
    KIND_TOO_LARGE = 3'd4
  } kind_t;

  typedef struct packed {
    role_t      role;
    logic [7:0] data;
  } entry_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> src/fpr_front.sv
// Front end: tracks frame position and tags each in-frame byte with its role.
module fpr_front
  import fpr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  phase_t      phase, phase_next;
  logic [7:0]  len_lo, len_lo_next;
  logic [15:0] length, length_next;
  logic [7:0]  count, count_next;
  logic        accept;
  logic [15:0] hi_length;

  assign rx_stall  = q_full;
  assign accept    = rx_valid && !q_full;
  assign hi_length = {rx_byte, len_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HUNT;
      len_lo <= '0;
      length <= '0;
      count  <= '0;
    end else begin
      phase  <= phase_next;
      len_lo <= len_lo_next;
      length <= length_next;
      count  <= count_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    len_lo_next   = len_lo;
    length_next   = length;
    count_next    = count;
    q_push        = 1'b0;
    q_entry.data  = rx_byte;
    q_entry.role  = ROLE_TYPE;
    if (accept) begin
      q_push = (phase != PH_HUNT);
      case (phase)
        PH_HUNT: begin
          if (rx_byte == HEAD_BYTE) phase_next = PH_TYPE;
        end
        PH_TYPE: begin
          q_entry.role = ROLE_TYPE;
          phase_next   = PH_SEQ;
        end
        PH_SEQ: begin
          q_entry.role = ROLE_SEQ;
          phase_next   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          q_entry.role = ROLE_LEN_LO;
          len_lo_next  = rx_byte;
          phase_next   = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          q_entry.role = ROLE_LEN_HI;
          length_next  = hi_length;
          count_next   = '0;
          if (hi_length > 16'(MAX_PAYLOAD)) begin
            phase_next = PH_HUNT;
          end else if (hi_length == '0) begin
            phase_next = PH_CRC;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          q_entry.role = ROLE_PAYLOAD;
          count_next   = count + 8'd1;
          if ({8'h00, count_next} >= length) phase_next = PH_CRC;
        end
        PH_CRC: begin
          q_entry.role = ROLE_CRC;
          phase_next   = PH_TAIL;
        end
        PH_TAIL: begin
          q_entry.role = ROLE_TAIL;
          phase_next   = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

endmodule

>>> src/fpr_queue.sv
// Small FIFO of tagged bytes between front and back end.
module fpr_queue
  import fpr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            do_push, do_pop;

  assign full       = (count == (AW+1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + AW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/fpr_back.sv
// Back end: CRC, held header fields and result register.
module fpr_back
  import fpr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        q_pop,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_seq,
  output logic [15:0] payload_len
);

  logic [7:0]  held_type, held_seq, crc_accum;
  logic [15:0] held_length;
  logic        crc_ok;
  kind_t       res_kind;
  logic [15:0] new_length;
  logic        too_large, needs_out, slot_free, emit;
  logic [7:0]  crc_new;

  assign new_length = {q_entry.data, held_length[7:0]};
  assign too_large  = new_length > 16'(MAX_PAYLOAD);
  assign crc_new    = crc_update((q_entry.role == ROLE_TYPE) ? CRC_INIT : crc_accum,
                                 q_entry.data);
  assign needs_out  = (q_entry.role == ROLE_PAYLOAD) || (q_entry.role == ROLE_TAIL) ||
                      ((q_entry.role == ROLE_LEN_HI) && too_large);
  assign slot_free  = !res_valid || !res_stall;
  assign q_pop      = q_valid && (!needs_out || slot_free);
  assign emit       = q_pop && needs_out;
  assign kind       = res_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_type   <= '0;
      held_seq    <= '0;
      held_length <= '0;
      crc_accum   <= CRC_INIT;
      crc_ok      <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (q_pop) begin
        case (q_entry.role)
          ROLE_TYPE: begin
            held_type <= q_entry.data;
            crc_accum <= crc_new;
            crc_ok    <= 1'b0;
          end
          ROLE_SEQ: begin
            held_seq  <= q_entry.data;
            crc_accum <= crc_new;
          end
          ROLE_LEN_LO: begin
            held_length <= {8'h00, q_entry.data};
            crc_accum   <= crc_new;
          end
          ROLE_LEN_HI: begin
            held_length <= new_length;
            crc_accum   <= crc_new;
          end
          ROLE_PAYLOAD: begin
            crc_accum <= crc_new;
          end
          ROLE_CRC: begin
            crc_ok <= (q_entry.data == crc_accum);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      payload_byte <= '0;
      frame_type   <= held_type;
      frame_seq    <= held_seq;
      payload_len  <= held_length;
      case (q_entry.role)
        ROLE_PAYLOAD: begin
          res_kind     <= KIND_PAYLOAD;
          payload_byte <= q_entry.data;
        end
        ROLE_LEN_HI: begin
          res_kind    <= KIND_TOO_LARGE;
          payload_len <= new_length;
        end
        default: begin
          if (!crc_ok) begin
            res_kind <= KIND_CRC_ERR;
          end else if (q_entry.data != TAIL_BYTE) begin
            res_kind <= KIND_BAD_TAIL;
          end else begin
            res_kind <= KIND_ACCEPTED;
          end
        end
      endcase
    end
  end

endmodule

>>> src/framed_packet_receiver.sv
// Top level of the framed packet receiver: front end, queue, back end.
//
//   channel  handshake             data
//   rx       rx_valid / rx_stall   rx_byte
//   res      res_valid / res_stall kind, payload_byte, frame_type, frame_seq, payload_len
//
// One byte per cycle sustained while rx_stall is low; a result-bearing byte passes through
// the four-entry queue and then the result register before its result appears.
// rst is synchronous: parser hunts for the head byte, queue empties, no result pending.
// rx_stall rises only when the queue is full: a result held by res_stall, a result-bearing
// transfer blocked at the queue head and three more transfers behind it.
module framed_packet_receiver
  import fpr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_seq,
  output logic [15:0] payload_len
);

  logic   q_full, q_push, q_pop, q_valid;
  entry_t push_entry, head_entry;

  fpr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  fpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  fpr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (head_entry),
    .q_pop        (q_pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .frame_type   (frame_type),
    .frame_seq    (frame_seq),
    .payload_len  (payload_len)
  );

endmodule
